>>> sv/syard_pkg.sv
// Shared types, constants and helper functions for the shunting-yard converter.
package syard_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [7:0]       sym_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam count_t DEPTH_CNT = count_t'(STACK_DEPTH);
  localparam count_t TWO_CNT   = count_t'(2);

  localparam sym_t CH_OPEN  = 8'h28;
  localparam sym_t CH_CLOSE = 8'h29;
  localparam sym_t CH_PLUS  = 8'h2B;
  localparam sym_t CH_MINUS = 8'h2D;
  localparam sym_t CH_STAR  = 8'h2A;
  localparam sym_t CH_SLASH = 8'h2F;
  localparam sym_t CH_PCT   = 8'h25;

  typedef enum logic [1:0] {
    STAT_SYMBOL    = 2'd0,
    STAT_DONE      = 2'd1,
    STAT_OVERFLOW  = 2'd2,
    STAT_UNMATCHED = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_WORK
  } fsm_state_t;

  typedef struct packed {
    sym_t in_symbol;
    logic end_of_expr;
  } in_item_t;

  typedef struct packed {
    sym_t    out_symbol;
    status_t status;
    logic    last;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    sym_t data;
  } stack_op_t;

  function automatic logic is_alnum(input sym_t c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  // A stacked open paren ranks below every operator.
  function automatic logic [1:0] prec_of(input sym_t c);
    logic [1:0] p;
    if (c == CH_OPEN) begin
      p = 2'd0;
    end else if (c inside {CH_PLUS, CH_MINUS}) begin
      p = 2'd1;
    end else if (c inside {CH_STAR, CH_SLASH, CH_PCT}) begin
      p = 2'd2;
    end else begin
      p = 2'd3;
    end
    return p;
  endfunction

endpackage

>>> sv/syard_cell.sv
// One entry of the operator stack; shifts toward its neighbors on push and pop.
module syard_cell (
  input  logic               clk,
  input  syard_pkg::stack_op_t op,
  input  syard_pkg::sym_t    from_above,
  input  syard_pkg::sym_t    from_below,
  output syard_pkg::sym_t    value
);
  import syard_pkg::*;

  // Push moves everything one place deeper, pop moves everything one place up.
  always_ff @(posedge clk) begin
    if (op.push) begin
      value <= from_above;
    end else if (op.pop) begin
      value <= from_below;
    end
  end

endmodule

>>> sv/syard_ctrl.sv
// Sequencer: takes an item, steps the stack one pop or push a cycle while the output is free, registers results.
module syard_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  syard_pkg::in_item_t   char_item,
  output logic                  post_valid,
  input  logic                  post_stall,
  output syard_pkg::out_item_t  post_item,
  input  syard_pkg::sym_t       top0,
  input  syard_pkg::sym_t       top1,
  output syard_pkg::stack_op_t  op
);
  import syard_pkg::*;

  fsm_state_t state, state_next;
  count_t     count;
  in_item_t   cur;
  logic       can_load;
  logic       emit;
  logic       finish;
  out_item_t  emit_item;
  logic [1:0] prec_in;
  logic       deep;

  assign char_stall = (state != FSM_IDLE);
  assign can_load   = !post_valid || !post_stall;
  assign prec_in    = prec_of(cur.in_symbol);
  assign deep       = (count >= TWO_CNT);

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (char_valid) state_next = FSM_WORK;
      end
      FSM_WORK: begin
        if (finish) state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // One stack action per cycle, taken only when the output register is free.
  always_comb begin
    op        = '0;
    op.data   = cur.in_symbol;
    emit      = 1'b0;
    finish    = 1'b0;
    emit_item = '{out_symbol: '0, status: STAT_SYMBOL, last: 1'b0};
    if (state == FSM_WORK && can_load) begin
      if (cur.end_of_expr) begin
        if (count != '0) begin
          op.pop = 1'b1;
          if (top0 != CH_OPEN) begin
            emit                 = 1'b1;
            emit_item.out_symbol = top0;
          end
        end else begin
          emit             = 1'b1;
          emit_item.status = STAT_DONE;
          emit_item.last   = 1'b1;
          finish           = 1'b1;
        end
      end else if (is_alnum(cur.in_symbol)) begin
        emit                 = 1'b1;
        emit_item.out_symbol = cur.in_symbol;
        emit_item.last       = 1'b1;
        finish               = 1'b1;
      end else if (cur.in_symbol == CH_OPEN) begin
        finish = 1'b1;
        if (count < DEPTH_CNT) begin
          op.push = 1'b1;
        end else begin
          emit             = 1'b1;
          emit_item.status = STAT_OVERFLOW;
          emit_item.last   = 1'b1;
        end
      end else if (cur.in_symbol == CH_CLOSE) begin
        if (count != '0) begin
          op.pop = 1'b1;
          if (top0 == CH_OPEN) begin
            finish = 1'b1;
          end else begin
            emit                 = 1'b1;
            emit_item.out_symbol = top0;
            emit_item.last       = deep && (top1 == CH_OPEN);
          end
        end else begin
          emit             = 1'b1;
          emit_item.status = STAT_UNMATCHED;
          emit_item.last   = 1'b1;
          finish           = 1'b1;
        end
      end else begin
        if (count != '0 && prec_in <= prec_of(top0)) begin
          op.pop               = 1'b1;
          emit                 = 1'b1;
          emit_item.out_symbol = top0;
          emit_item.last       = !(deep && prec_in <= prec_of(top1));
        end else if (count < DEPTH_CNT) begin
          op.push = 1'b1;
          finish  = 1'b1;
        end else begin
          emit             = 1'b1;
          emit_item.status = STAT_OVERFLOW;
          emit_item.last   = 1'b1;
          finish           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FSM_IDLE;
      count      <= '0;
      post_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op.push) begin
        count <= count + count_t'(1);
      end else if (op.pop) begin
        count <= count - count_t'(1);
      end
      if (can_load) begin
        post_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FSM_IDLE && char_valid) begin
      cur <= char_item;
    end
    if (can_load && emit) begin
      post_item <= emit_item;
    end
  end

endmodule

>>> sv/infix_to_postfix_shunting_yard.sv
// Top level of the infix-to-postfix converter: sequencer plus operator stack cell chain.
//
// Converts a stream of infix characters into postfix order by the shunting-yard
// method. Each char item is one ASCII code, or an end mark that flushes the
// operator stack and then sends a completion result. Letters and digits come
// straight out; '(' is stacked; ')' sends stacked operators back out up to the
// matching '(' (an unmatched ')' empties the stack and reports status 3); any
// other code is an operator that first sends out every stacked operator of
// equal or higher precedence, then is stacked. A push onto a full stack drops
// the symbol and reports status 2. The last result caused by an item carries
// last = 1; an item may cause no result at all (a stacked '(' or an operator
// that pops nothing). The stack is a chain of STACK_DEPTH cells with the top
// at cell 0; every push or pop shifts the whole chain by one place. The
// sequencer takes one item, then performs its stack actions one at a time
// (each pop, the final push or the single emitted result). Each result sits
// in an output register, and a stalled output holds the sequencer until that
// register frees up.
module infix_to_postfix_shunting_yard (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  syard_pkg::in_item_t  char_item,
  output logic                 post_valid,
  input  logic                 post_stall,
  output syard_pkg::out_item_t post_item
);
  import syard_pkg::*;

  stack_op_t op;
  sym_t      cell_val [STACK_DEPTH];

  // Sequencer: owns the stack count and the output register.
  syard_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .post_valid (post_valid),
    .post_stall (post_stall),
    .post_item  (post_item),
    .top0       (cell_val[0]),
    .top1       (cell_val[1]),
    .op         (op)
  );

  // Operator stack: cell 0 is the top, pushes enter there and shift deeper.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    sym_t above;
    sym_t below;
    if (i == 0) begin : g_top
      assign above = op.data;
    end else begin : g_mid_above
      assign above = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_mid_below
      assign below = cell_val[i+1];
    end
    syard_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .value      (cell_val[i])
    );
  end

endmodule

>>> sv/syard_chk.sv
// Port-level checker for the shunting-yard converter, bound to the top level.
module syard_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 char_valid,
  input logic                 char_stall,
  input logic                 post_valid,
  input logic                 post_stall,
  input syard_pkg::out_item_t post_item
);
  import syard_pkg::*;

  // Hold a stalled result.
  a_post_hold: assert property (@(posedge clk) disable iff (rst)
    post_valid && post_stall |=> post_valid && $stable(post_item))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !post_valid)
    else $error("result shown right after reset");

  // Completion, overflow and unmatched results carry no symbol and close the item.
  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    post_valid && post_item.status != STAT_SYMBOL |->
      post_item.out_symbol == '0 && post_item.last)
    else $error("marker result malformed");

  a_no_open_out: assert property (@(posedge clk) disable iff (rst)
    post_valid && post_item.status == STAT_SYMBOL |-> post_item.out_symbol != CH_OPEN)
    else $error("open paren emitted");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall |=> char_stall)
    else $error("second item taken while busy");

endmodule

bind infix_to_postfix_shunting_yard syard_chk u_syard_chk (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .post_valid (post_valid),
  .post_stall (post_stall),
  .post_item  (post_item)
);

>>> tb/sv/tb.sv
// Testbench for the shunting-yard infix-to-postfix converter with a self-checking predictor.
`timescale 1ns / 1ps

module tb;
  import syard_pkg::*;

  // Allow this many cycles with no item moving on either side before giving up.
  localparam int IDLE_LIMIT = 2000;
  // Queue input items until at least this many are waiting, directed ones included.
  localparam int TOTAL_ITEMS = 370;

  logic      clk;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_stall;
  in_item_t  char_item = '0;
  logic      post_valid;
  logic      post_stall = 1'b0;
  out_item_t post_item;

  infix_to_postfix_shunting_yard u_dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item (char_item),
    .post_valid(post_valid),
    .post_stall(post_stall),
    .post_item (post_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Characters waiting to be sent, and postfix results still owed by the block.
  in_item_t  char_q[$];
  out_item_t postfix_q[$];

  // Predictor copy of the operator stack.
  sym_t opstack[STACK_DEPTH];
  int   op_depth = 0;

  int fail_cnt = 0;
  int idle_cnt = 0;
  logic char_taken = 1'b0;
  logic post_taken = 1'b0;

  function automatic bit passes_through(input sym_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Binding strength; a stacked open paren sits below every operator.
  function automatic int rank_of(input sym_t c);
    if (c == CH_OPEN) return 0;
    if (c == CH_PLUS || c == CH_MINUS) return 1;
    if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) return 2;
    return 3;
  endfunction

  function automatic out_item_t make_result(input sym_t s, input status_t st);
    out_item_t r;
    r.out_symbol = s;
    r.status = st;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the postfix results one accepted character causes, in order.
  task automatic convert_char(input in_item_t it);
    out_item_t batch[$];
    sym_t c;
    sym_t top;
    bit matched;
    c = it.in_symbol;
    if (it.end_of_expr) begin
      // Flush: stacked open parens vanish, everything else comes out.
      while (op_depth > 0) begin
        op_depth--;
        top = opstack[op_depth];
        if (top != CH_OPEN) batch.push_back(make_result(top, STAT_SYMBOL));
      end
      batch.push_back(make_result(8'h00, STAT_DONE));
    end else if (passes_through(c)) begin
      batch.push_back(make_result(c, STAT_SYMBOL));
    end else if (c == CH_OPEN) begin
      if (op_depth >= STACK_DEPTH) begin
        batch.push_back(make_result(8'h00, STAT_OVERFLOW));
      end else begin
        opstack[op_depth] = c;
        op_depth++;
      end
    end else if (c == CH_CLOSE) begin
      matched = 1'b0;
      while (op_depth > 0 && !matched) begin
        op_depth--;
        top = opstack[op_depth];
        if (top == CH_OPEN) matched = 1'b1;
        else batch.push_back(make_result(top, STAT_SYMBOL));
      end
      if (!matched) batch.push_back(make_result(8'h00, STAT_UNMATCHED));
    end else begin
      // Pop everything that binds at least as tightly, then stack the operator.
      while (op_depth > 0 && rank_of(c) <= rank_of(opstack[op_depth-1])) begin
        op_depth--;
        batch.push_back(make_result(opstack[op_depth], STAT_SYMBOL));
      end
      if (op_depth >= STACK_DEPTH) begin
        batch.push_back(make_result(8'h00, STAT_OVERFLOW));
      end else begin
        opstack[op_depth] = c;
        op_depth++;
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) postfix_q.push_back(batch[i]);
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Sender: present one item, hold it while stalled, then wait its drawn gap.
  int send_wait = 0;
  bit send_calm = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_taken) begin
      if (send_wait > 0) begin
        send_wait = send_wait - 1;
        char_valid <= 1'b0;
      end else if (char_q.size() > 0) begin
        char_item <= char_q.pop_front();
        char_valid <= 1'b1;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_wait = draw_wait(send_calm);
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // Receiver: after each taken result, stall for a drawn number of cycles.
  int recv_wait = 0;
  bit recv_calm = 1'b0;
  always @(negedge clk) begin
    if (post_taken) begin
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      recv_wait = draw_wait(recv_calm);
    end
    if (!rst && recv_wait > 0) begin
      recv_wait = recv_wait - 1;
      post_stall <= 1'b1;
    end else begin
      post_stall <= 1'b0;
    end
  end

  // Monitor: predict on every accepted character, check every accepted result.
  always @(posedge clk) begin
    out_item_t want;
    char_taken <= !rst && char_valid && !char_stall;
    post_taken <= !rst && post_valid && !post_stall;
    if (!rst) begin
      if (char_valid && !char_stall) convert_char(char_item);
      if (post_valid && !post_stall) begin
        if (postfix_q.size() == 0) begin
          $error("result with nothing expected: out_symbol %0h status %0d last %0b",
                 post_item.out_symbol, post_item.status, post_item.last);
          fail_cnt++;
        end else begin
          want = postfix_q.pop_front();
          if (post_item.out_symbol !== want.out_symbol) begin
            $error("out_symbol expected %0h actual %0h", want.out_symbol, post_item.out_symbol);
            fail_cnt++;
          end
          if (post_item.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, post_item.status);
            fail_cnt++;
          end
          if (post_item.last !== want.last) begin
            $error("last expected %0b actual %0b", want.last, post_item.last);
            fail_cnt++;
          end
        end
      end
      if ((char_valid && !char_stall) || (post_valid && !post_stall)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic sym_t rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return sym_t'(8'h30 + r);
    if (r < 36) return sym_t'(8'h41 + r - 10);
    return sym_t'(8'h61 + r - 36);
  endfunction

  // Any operator: mostly the five arithmetic ones, else any other non-operand code.
  function automatic sym_t rand_operator();
    sym_t c;
    case ($urandom_range(0, 7))
      0: c = CH_PLUS;
      1: c = CH_MINUS;
      2: c = CH_STAR;
      3: c = CH_SLASH;
      4: c = CH_PCT;
      default: begin
        c = sym_t'($urandom_range(0, 255));
        while (passes_through(c) || c == CH_OPEN || c == CH_CLOSE)
          c = sym_t'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  task automatic add_char(input sym_t c);
    in_item_t it;
    it.in_symbol = c;
    it.end_of_expr = 1'b0;
    char_q.push_back(it);
  endtask

  task automatic add_end();
    in_item_t it;
    it.in_symbol = sym_t'($urandom_range(0, 255));
    it.end_of_expr = 1'b1;
    char_q.push_back(it);
  endtask

  // Well-formed expression with random nesting, then the end mark.
  task automatic add_expression(input int terms);
    int nest;
    nest = 0;
    for (int t = 0; t < terms; t++) begin
      while ($urandom_range(0, 3) == 0 && nest < 6) begin
        add_char(CH_OPEN);
        nest++;
      end
      add_char(rand_alnum());
      while (nest > 0 && $urandom_range(0, 2) == 0) begin
        add_char(CH_CLOSE);
        nest--;
      end
      if (t < terms - 1) add_char(rand_operator());
    end
    while (nest > 0) begin
      add_char(CH_CLOSE);
      nest--;
    end
    add_end();
  endtask

  // Drive the stack toward full, mostly with open parens, then unwind.
  task automatic add_deep_fill();
    int n;
    n = $urandom_range(30, 38);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) add_char(rand_operator());
      else add_char(CH_OPEN);
    end
    add_char($urandom_range(0, 1) ? CH_OPEN : rand_operator());
    repeat ($urandom_range(0, 4)) add_char(CH_CLOSE);
    add_end();
  endtask

  // Random bytes with a sprinkling of end marks, parens and operands.
  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_end();
        1: add_char(CH_OPEN);
        2: add_char(CH_CLOSE);
        3: add_char(rand_alnum());
        default: add_char(sym_t'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    int total;
    // Operands of every kind, every precedence level, nesting and both paren errors.
    add_char("a"); add_char(CH_PLUS); add_char("b"); add_char(CH_STAR); add_char("c");
    add_char("^"); add_char("d"); add_char(CH_MINUS);
    add_char(CH_OPEN); add_char("Z"); add_char(CH_PCT); add_char("9"); add_char(CH_CLOSE);
    add_char(CH_SLASH); add_char("0"); add_char(8'h00); add_char(8'hFF); add_end();
    add_char(CH_CLOSE);
    add_char(CH_OPEN); add_char(CH_OPEN); add_char(CH_PLUS); add_char("z");
    add_char(CH_CLOSE); add_end();
    add_char("A"); add_char(CH_PLUS); add_char(CH_CLOSE);

    // Fill the stack exactly, then push an operator and a paren onto it.
    repeat (STACK_DEPTH) add_char(CH_OPEN);
    add_char(CH_PLUS);
    add_char(CH_OPEN);
    add_end();

    total = TOTAL_ITEMS;
    while (char_q.size() < total) begin
      case ($urandom_range(0, 9))
        0: add_deep_fill();
        1, 2: add_noise($urandom_range(3, 15));
        default: add_expression($urandom_range(1, 8));
      endcase
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (char_q.size() != 0 || char_valid) @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
    // Give any stray results time to show up.
    repeat (60) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/syard_pkg.sv
sv/syard_cell.sv
sv/syard_ctrl.sv
sv/infix_to_postfix_shunting_yard.sv
sv/syard_chk.sv
tb/sv/tb.sv
